### hdl/u2l_pkg.sv
// Shared types, constants and the code point fold function of the UTF-8 to
// Latin-1 decoder. No dependencies; used by every module of the block.
package u2l_pkg;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  localparam logic [7:0]  ReplCode   = 8'h3F;
  localparam logic [7:0]  DashCode   = 8'h2D;
  localparam logic [7:0]  QuoteCode  = 8'h27;
  localparam logic [20:0] EnDash     = 21'h002013;
  localparam logic [20:0] EmDash     = 21'h002014;
  localparam logic [20:0] LeftQuote  = 21'h002018;
  localparam logic [20:0] RightQuote = 21'h002019;

  typedef struct packed {
    logic [7:0] code;
    logic       run_last;
    logic       text_end;
  } result_t;

  typedef struct packed {
    logic [1:0] num;
    result_t    r0;
    result_t    r1;
  } push_t;

  function automatic logic [7:0] fold_code(input logic [20:0] v);
    logic [7:0] res;
    if (v == EnDash || v == EmDash) begin
      res = DashCode;
    end else if (v == LeftQuote || v == RightQuote) begin
      res = QuoteCode;
    end else if (v[20:8] == 13'd0 && v[7:5] != 3'd0) begin
      res = v[7:0];
    end else begin
      res = ReplCode;
    end
    return res;
  endfunction

endpackage

### hdl/u2l_queue.sv
// Result queue of the UTF-8 to Latin-1 decoder: takes up to two results a
// cycle and offers one to the output channel. Depends on u2l_pkg.
module u2l_queue (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  u2l_pkg::push_t                push_i,
  output logic                          room_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output u2l_pkg::result_t              head_o
);

  u2l_pkg::result_t                     mem_q [u2l_pkg::QueueDepth];
  logic [u2l_pkg::QueuePtrW-1:0]        wr_ptr_q, wr_ptr_d;
  logic [u2l_pkg::QueuePtrW-1:0]        rd_ptr_q, rd_ptr_d;
  logic [u2l_pkg::QueueCntW-1:0]        cnt_q, cnt_d;
  logic                                 pop;

  assign out_valid_o = (cnt_q != '0);
  assign head_o      = mem_q[rd_ptr_q];
  assign room_o      = (cnt_q <= u2l_pkg::QueueCntW'(u2l_pkg::QueueDepth - 2));
  assign pop         = out_valid_o && !out_stall_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q + u2l_pkg::QueuePtrW'(push_i.num);
    rd_ptr_d = rd_ptr_q + u2l_pkg::QueuePtrW'(pop);
    cnt_d    = cnt_q + u2l_pkg::QueueCntW'(push_i.num) - u2l_pkg::QueueCntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.r0;
    end
    if (push_i.num == 2'd2) begin
      mem_q[wr_ptr_q + u2l_pkg::QueuePtrW'(1)] <= push_i.r1;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= u2l_pkg::QueueCntW'(u2l_pkg::QueueDepth))
    else $error("result queue overfilled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.num != 2'd0 |-> room_o)
    else $error("results pushed without room");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0 && push_i.num == 2'd0) |=> !out_valid_o)
    else $error("result offered from an empty queue");

endmodule

### hdl/u2l_decode.sv
// Input register, sequence state and single-pass decode of one UTF-8 byte
// into up to two Latin-1 results. Depends on u2l_pkg.
module u2l_decode (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic [7:0]     text_byte_i,
  input  logic           final_byte_i,
  input  logic           room_i,
  output u2l_pkg::push_t push_o
);

  logic             in_vld_q, in_vld_d;
  logic [7:0]       in_byte_q;
  logic             in_final_q;
  logic [1:0]       pend_q, pend_n;
  logic [20:0]      val_q, val_n;
  logic             take;
  logic [20:0]      gathered;
  logic [1:0]       num;
  logic [1:0][7:0]  cd;

  assign take       = in_vld_q && room_i;
  assign in_stall_o = in_vld_q && !take;
  assign in_vld_d   = in_stall_o ? in_vld_q : in_valid_i;
  assign gathered   = {val_q[14:0], in_byte_q[5:0]};

  always_comb begin
    pend_n = pend_q;
    val_n  = val_q;
    num    = 2'd0;
    cd     = '0;
    if (pend_q != 2'd0 && in_byte_q[7:6] == 2'b10) begin
      pend_n = pend_q - 2'd1;
      val_n  = gathered;
      if (pend_n == 2'd0) begin
        cd[0] = u2l_pkg::fold_code(gathered);
        num   = 2'd1;
      end
    end else begin
      pend_n = 2'd0;
      val_n  = '0;
      if (pend_q != 2'd0) begin
        cd[0] = u2l_pkg::ReplCode;
        num   = 2'd1;
      end
      if (!in_byte_q[7]) begin
        cd[num[0]] = in_byte_q;
        num        = num + 2'd1;
      end else if (in_byte_q[7:5] == 3'b110) begin
        pend_n = 2'd1;
        val_n  = {16'd0, in_byte_q[4:0]};
      end else if (in_byte_q[7:4] == 4'b1110) begin
        pend_n = 2'd2;
        val_n  = {17'd0, in_byte_q[3:0]};
      end else if (in_byte_q[7:3] == 5'b11110) begin
        pend_n = 2'd3;
        val_n  = {18'd0, in_byte_q[2:0]};
      end else begin
        cd[num[0]] = u2l_pkg::ReplCode;
        num        = num + 2'd1;
      end
    end
    if (in_final_q) begin
      if (pend_n != 2'd0 && num < 2'd2) begin
        cd[num[0]] = u2l_pkg::ReplCode;
        num        = num + 2'd1;
      end
      pend_n = 2'd0;
      val_n  = '0;
    end
  end

  always_comb begin
    push_o.num         = take ? num : 2'd0;
    push_o.r0.code     = cd[0];
    push_o.r0.run_last = (num == 2'd1);
    push_o.r0.text_end = (num == 2'd1) && in_final_q;
    push_o.r1.code     = cd[1];
    push_o.r1.run_last = 1'b1;
    push_o.r1.text_end = in_final_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      pend_q   <= 2'd0;
      val_q    <= '0;
    end else begin
      in_vld_q <= in_vld_d;
      if (take) begin
        pend_q <= pend_n;
        val_q  <= val_n;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o) begin
      in_byte_q  <= text_byte_i;
      in_final_q <= final_byte_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && in_final_q) |=> (pend_q == 2'd0 && val_q == '0))
    else $error("sequence state not cleared after final byte");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && in_final_q) |-> push_o.num != 2'd0)
    else $error("final byte produced no result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.num != 2'd3)
    else $error("more than two results for one byte");

endmodule

### hdl/utf8_to_latin1_decoder_core.sv
// Top level of the UTF-8 to Latin-1 decoder.
// Depends on u2l_pkg, u2l_decode and u2l_queue.
//
// Usage:
//   Input channel: one UTF-8 byte per request on text_byte_i, with
//   final_byte_i marking the last byte of a text. Output channel: one
//   Latin-1 code per request on latin_code_o, with run_last_o on the last
//   result of a byte and text_end_o on the last result of the text.
//   Both channels move a request on a rising edge with valid high, stall low.
// Path: an accepted byte passes through the input register and the
//   four-entry result queue before its first result is offered.
// Throughput: one byte per cycle while the receiver takes results. A byte
//   that yields two results (a broken sequence) fills two queue entries;
//   lead bytes that neither end a text nor break a sequence yield none. The
//   queue limits intake when it holds more than two results.
// Reset: clears the input valid flag, the sequence state and the queue.
// Receiver stall: results wait in the queue; once it is nearly full the
//   input stall rises and the pending byte holds in the input register.
module utf8_to_latin1_decoder_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] text_byte_i,
  input  logic       final_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] latin_code_o,
  output logic       run_last_o,
  output logic       text_end_o
);

  u2l_pkg::push_t   push;
  u2l_pkg::result_t head;
  logic             room;

  u2l_decode u_decode (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .text_byte_i  (text_byte_i),
    .final_byte_i (final_byte_i),
    .room_i       (room),
    .push_o       (push)
  );

  u2l_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .head_o      (head)
  );

  assign latin_code_o = head.code;
  assign run_last_o   = head.run_last;
  assign text_end_o   = head.text_end;

endmodule

### test/tb_top.sv
// Testbench of utf8_to_latin1_decoder_core: feeds directed and random UTF-8
// texts with random bursts and output stalls, and checks every Latin-1 result.
// Depends on u2l_pkg and the decoder RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] b;
    logic       fin;
  } text_req_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall_o;
  logic [7:0] text_byte = 8'h00;
  logic       final_byte = 1'b0;
  logic       out_valid_o;
  logic       out_stall = 1'b1;
  logic [7:0] latin_code_o;
  logic       run_last_o;
  logic       text_end_o;

  text_req_t          pending_bytes[$];
  u2l_pkg::result_t   expected_results[$];
  text_req_t          next_req;
  u2l_pkg::result_t   got_result;

  logic [1:0]  seq_left = 2'd0;
  logic [20:0] cp_acc = 21'd0;

  int error_count = 0;
  int bytes_sent = 0;
  int texts_sent = 0;
  int results_seen = 0;
  int double_bytes = 0;
  int burst_left = 0;
  int gap_left = 0;
  int stall_mode = 0;
  int stall_left = 0;

  utf8_to_latin1_decoder_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .text_byte_i (text_byte),
    .final_byte_i(final_byte),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .latin_code_o(latin_code_o),
    .run_last_o  (run_last_o),
    .text_end_o  (text_end_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic logic [7:0] latin_fold(input logic [20:0] v);
    if (v == u2l_pkg::EnDash || v == u2l_pkg::EmDash) return u2l_pkg::DashCode;
    if (v == u2l_pkg::LeftQuote || v == u2l_pkg::RightQuote) return u2l_pkg::QuoteCode;
    if (v >= 21'd32 && v <= 21'd255) return v[7:0];
    return u2l_pkg::ReplCode;
  endfunction

  function automatic void decode_byte(input logic [7:0] b, input logic fin);
    logic [7:0] codes[2];
    int n;
    u2l_pkg::result_t r;
    n = 0;
    if (seq_left != 2'd0 && b[7:6] == 2'b10) begin
      cp_acc = {cp_acc[14:0], b[5:0]};
      seq_left = seq_left - 2'd1;
      if (seq_left == 2'd0) begin
        codes[n] = latin_fold(cp_acc);
        n++;
      end
    end else begin
      if (seq_left != 2'd0) begin
        codes[n] = u2l_pkg::ReplCode;
        n++;
        seq_left = 2'd0;
        cp_acc = 21'd0;
      end
      if (!b[7]) begin
        codes[n] = b;
        n++;
      end else if (b[7:5] == 3'b110) begin
        seq_left = 2'd1;
        cp_acc = {16'd0, b[4:0]};
      end else if (b[7:4] == 4'b1110) begin
        seq_left = 2'd2;
        cp_acc = {17'd0, b[3:0]};
      end else if (b[7:3] == 5'b11110) begin
        seq_left = 2'd3;
        cp_acc = {18'd0, b[2:0]};
      end else begin
        codes[n] = u2l_pkg::ReplCode;
        n++;
      end
    end
    if (fin) begin
      if (seq_left != 2'd0 && n < 2) begin
        codes[n] = u2l_pkg::ReplCode;
        n++;
      end
      seq_left = 2'd0;
      cp_acc = 21'd0;
      texts_sent++;
    end
    if (n == 2) double_bytes++;
    for (int k = 0; k < n; k++) begin
      r.code = codes[k];
      r.run_last = (k == n - 1);
      r.text_end = (k == n - 1) && fin;
      expected_results.push_back(r);
    end
  endfunction

  function automatic void push_byte(input logic [7:0] b, input logic fin);
    text_req_t req;
    req.b = b;
    req.fin = fin;
    pending_bytes.push_back(req);
  endfunction

  function automatic logic [7:0] cont_byte();
    return 8'h80 | 8'($urandom_range(0, 63));
  endfunction

  function automatic void add_random_text();
    logic [7:0] txt[$];
    int len;
    int kind;
    int nconts;
    len = $urandom_range(1, 10);
    for (int i = 0; i < len; i++) begin
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
        txt.push_back(8'($urandom_range(1, 127)));
      end else if (kind < 50) begin
        txt.push_back(8'hC0 | 8'($urandom_range(0, 31)));
        txt.push_back(cont_byte());
      end else if (kind < 70) begin
        if ($urandom_range(0, 2) == 0) begin
          txt.push_back(8'hE2);
          txt.push_back(8'h80);
          case ($urandom_range(0, 3))
            0: txt.push_back(8'h93);
            1: txt.push_back(8'h94);
            2: txt.push_back(8'h98);
            default: txt.push_back(8'h99);
          endcase
        end else begin
          txt.push_back(8'hE0 | 8'($urandom_range(0, 15)));
          txt.push_back(cont_byte());
          txt.push_back(cont_byte());
        end
      end else if (kind < 82) begin
        txt.push_back(8'hF0 | 8'($urandom_range(0, 7)));
        for (int j = 0; j < 3; j++) txt.push_back(cont_byte());
      end else if (kind < 88) begin
        // three- or four-byte lead with zero to two continuations, often cut short
        nconts = $urandom_range(0, 2);
        txt.push_back($urandom_range(0, 1) ? (8'hE0 | 8'($urandom_range(0, 15)))
                                           : (8'hF0 | 8'($urandom_range(0, 7))));
        for (int j = 0; j < nconts; j++) txt.push_back(cont_byte());
      end else if (kind < 92) begin
        txt.push_back(cont_byte());
      end else if (kind < 95) begin
        txt.push_back(8'($urandom_range(8'hF8, 8'hFF)));
      end else begin
        txt.push_back(8'($urandom_range(1, 255)));
      end
    end
    foreach (txt[i]) push_byte(txt[i], i == txt.size() - 1);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      text_byte <= 8'h00;
      final_byte <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall_o) begin
        decode_byte(text_byte, final_byte);
        bytes_sent++;
      end
      if (!in_valid || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_bytes.size() > 0) begin
          next_req = pending_bytes.pop_front();
          in_valid <= 1'b1;
          text_byte <= next_req.b;
          final_byte <= next_req.fin;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b1;
      stall_mode = 0;
      stall_left = 0;
    end else begin
      if (out_valid_o && !out_stall) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("unexpected result: latin_code %0h run_last %0b text_end %0b",
                 latin_code_o, run_last_o, text_end_o);
          error_count++;
        end else begin
          got_result = expected_results.pop_front();
          if (latin_code_o !== got_result.code) begin
            $error("latin_code: expected %0h, got %0h", got_result.code, latin_code_o);
            error_count++;
          end
          if (run_last_o !== got_result.run_last) begin
            $error("run_last: expected %0b, got %0b", got_result.run_last, run_last_o);
            error_count++;
          end
          if (text_end_o !== got_result.text_end) begin
            $error("text_end: expected %0b, got %0b", got_result.text_end, text_end_o);
            error_count++;
          end
        end
      end
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(5, 60);
      end else begin
        stall_left--;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 1) == 0);
        2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= stall_left[0];
      endcase
    end
  end

  initial begin
    // ASCII extremes and pass-through
    push_byte(8'h41, 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(8'h7F, 1'b1);
    // two-byte and overlong two-byte forms
    push_byte(8'hC3, 1'b0);
    push_byte(8'hA9, 1'b0);
    push_byte(8'hC1, 1'b0);
    push_byte(8'hBF, 1'b0);
    // en dash and right quote
    push_byte(8'hE2, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'h93, 1'b0);
    push_byte(8'hE2, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'h99, 1'b0);
    // largest four-byte value
    push_byte(8'hF7, 1'b0);
    push_byte(8'hBF, 1'b0);
    push_byte(8'hBF, 1'b0);
    push_byte(8'hBF, 1'b0);
    // bad leads
    push_byte(8'h80, 1'b0);
    push_byte(8'hFF, 1'b0);
    // broken sequence restarting as ASCII, then as a new lead cut off at the end
    push_byte(8'hC3, 1'b0);
    push_byte(8'h41, 1'b0);
    push_byte(8'hC3, 1'b0);
    push_byte(8'hE2, 1'b0);
    push_byte(8'h80, 1'b1);
    // lone lead as the whole text
    push_byte(8'hC3, 1'b1);
    while (pending_bytes.size() < 825) add_random_text();

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_bytes.size() > 0 || in_valid) @(negedge clk_i);
    while (expected_results.size() > 0) @(negedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("decoded %0d bytes in %0d texts, checked %0d results", bytes_sent, texts_sent,
             results_seen);
    $display("%0d bytes gave two results", double_bytes);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", expected_results.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
